### sv/audio_onset_slice_detector_defines.svh
// ----------------------------------------------------------------------------
// audio onset slice detector assertion macros
// shared assertion helpers clocked on clk with rst_n as the disable
// ----------------------------------------------------------------------------
`ifndef AUDIO_ONSET_SLICE_DETECTOR_DEFINES_SVH
`define AUDIO_ONSET_SLICE_DETECTOR_DEFINES_SVH

// same-cycle implication
`define AOSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AOSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/aosd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aosd_pkg
// widths, register codes and reset values for the onset slice detector
// ----------------------------------------------------------------------------
package aosd_pkg;

    // field and state widths
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 31;
    localparam int ENERGY_W   = 42;
    localparam int WLEN_W     = 12;
    localparam int RMS_W      = 15;
    localparam int RMS_SQ_W   = 30;
    localparam int GAP_W      = 16;
    localparam int CNT_W      = 7;
    localparam int PHASE_W    = 11;
    localparam int NSLOT      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_MODE   = 3'd0,
        CFG_WINDOW_LENGTH = 3'd1,
        CFG_RMS_THRESHOLD = 3'd2,
        CFG_MIN_GAP       = 3'd3,
        CFG_SLICE_LIMIT   = 3'd4
    } cfg_reg_t;

    typedef logic [1:0] slot_idx_t;

    // detection modes
    localparam logic MODE_ENERGY = 1'b0;
    localparam logic MODE_ZERO_X = 1'b1;

    // register reset values
    localparam logic [WLEN_W-1:0]   RST_WINDOW_LENGTH = 12'd480;
    localparam logic [RMS_W-1:0]    RST_RMS_THRESHOLD = 15'd9830;
    localparam logic [GAP_W-1:0]    RST_MIN_GAP       = 16'd2400;
    localparam logic [CNT_W-1:0]    RST_SLICE_LIMIT   = 7'd16;
    localparam logic [RMS_SQ_W-1:0] RST_RMS_SQ        = 30'd96628900;
    localparam logic [ENERGY_W-1:0] RST_ENERGY_THR    = 42'd46381872000;
    localparam logic [WLEN_W-1:0]   MIN_WINDOW_LENGTH = 12'd2;

endpackage
`default_nettype wire

### sv/audio_onset_slice_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_onset_slice_detector
// energy transient and zero-crossing slice point detector over a sample stream
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  sample, last_sample
//   out       output     out_valid/out_stall  slice_valid, slice_position,
//                                             slice_count, end_of_buffer
//   cfg       input      cfg_write            cfg_index, cfg_data
//
// one sample beat per cycle sustained while out_stall is low
// the process stage window accumulate, judge and gap compare chain is combinational
// rst_n clears all buffer state and loads the register defaults
// out_stall holds the result register; one more beat waits in the input stage
// ----------------------------------------------------------------------------
`include "audio_onset_slice_detector_defines.svh"

module audio_onset_slice_detector #(
    parameter int SLICE_CAP     = 64,
    parameter int POSITION_BITS = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_write,
    input  wire logic [aosd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [aosd_pkg::CFG_DATA_W-1:0]        cfg_data,
    // sample input
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [aosd_pkg::SAMPLE_W-1:0]   sample,
    input  wire logic                                   last_sample,
    // result output
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        slice_valid,
    output logic [POSITION_BITS-1:0]                    slice_position,
    output logic [aosd_pkg::CNT_W-1:0]                  slice_count,
    output logic                                        end_of_buffer
);

    localparam int NSLOT = aosd_pkg::NSLOT;
    localparam logic [7:0] SLICE_CAP_L = 8'(SLICE_CAP);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [aosd_pkg::ENERGY_W-1:0] energy_t;

    // configuration registers
    logic                            detect_mode_reg;
    logic [aosd_pkg::WLEN_W-1:0]     window_length_reg;
    logic [aosd_pkg::GAP_W-1:0]      min_gap_reg;
    logic [aosd_pkg::CNT_W-1:0]      slice_limit_reg;
    logic [aosd_pkg::RMS_SQ_W-1:0]   rms_sq_reg;
    energy_t                         energy_thr_reg;

    // input stage
    logic                            in_full_reg;
    logic [aosd_pkg::MAG_W-1:0]      mag_reg;
    logic [aosd_pkg::SQ_W-1:0]       sq_reg;
    logic                            neg_reg;
    logic                            last_reg;

    // buffer state
    pos_t                            sample_index_reg, sample_index_next;
    energy_t                         energy_reg [NSLOT];
    energy_t                         energy_next [NSLOT];
    logic [aosd_pkg::MAG_W-1:0]      peak_mag_reg [NSLOT];
    logic [aosd_pkg::MAG_W-1:0]      peak_mag_next [NSLOT];
    pos_t                            peak_idx_reg [NSLOT];
    pos_t                            peak_idx_next [NSLOT];
    pos_t                            start_reg [NSLOT];
    pos_t                            start_next [NSLOT];
    logic [aosd_pkg::WLEN_W-1:0]     count_reg [NSLOT];
    logic [aosd_pkg::WLEN_W-1:0]     count_next [NSLOT];
    logic [NSLOT-1:0]                slot_valid_reg, slot_valid_next;
    aosd_pkg::slot_idx_t             slot_next_reg, slot_next_next;
    logic [aosd_pkg::PHASE_W-1:0]    hop_phase_reg, hop_phase_next;
    logic                            pend_valid_reg, pend_valid_next;
    energy_t                         pend_energy_reg, pend_energy_next;
    pos_t                            pend_start_reg, pend_start_next;
    pos_t                            pend_peak_reg, pend_peak_next;
    energy_t                         prev_energy_reg, prev_energy_next;
    pos_t                            last_slice_reg, last_slice_next;
    logic [aosd_pkg::CNT_W-1:0]      found_reg, found_next;
    logic                            prev_neg_reg, prev_neg_next;

    // result register
    logic                            out_valid_reg;
    logic                            slice_valid_reg;
    pos_t                            slice_position_reg;
    logic [aosd_pkg::CNT_W-1:0]      slice_count_reg;
    logic                            end_of_buffer_reg;

    logic                            hit_next;
    pos_t                            pos_next;
    logic [aosd_pkg::CNT_W-1:0]      count_res_next;

    logic                            advance;
    logic                            in_take;
    logic [aosd_pkg::MAG_W-1:0]      in_mag;
    logic [aosd_pkg::SQ_W-1:0]       in_sq;
    logic [aosd_pkg::WLEN_W-1:0]     wlen_eff;
    logic [aosd_pkg::PHASE_W-1:0]    hop;
    energy_t                         thr_prod;

    // slice budget check
    function automatic logic rec_ok(
        input logic [aosd_pkg::CNT_W-1:0] found,
        input logic [aosd_pkg::CNT_W-1:0] limit
    );
        return (limit != '0) && ({1'b0, limit} <= SLICE_CAP_L) && (found < limit);
    endfunction

    // gap beyond the previous slice point
    function automatic logic gap_ok(
        input pos_t                       at,
        input pos_t                       last_at,
        input logic [aosd_pkg::CNT_W-1:0] found,
        input logic [aosd_pkg::GAP_W-1:0] gap
    );
        pos_t diff;
        diff = at - last_at;
        return (found == '0) || ((at > last_at) && (33'(diff) > 33'(gap)));
    endfunction

    // handshake
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // magnitude and square of the incoming sample
    assign in_mag = sample[aosd_pkg::SAMPLE_W-1] ? 16'(-sample) : 16'(sample);
    assign in_sq  = {15'b0, in_mag} * {15'b0, in_mag};

    // effective window length, hop and energy threshold
    assign wlen_eff = (window_length_reg < aosd_pkg::MIN_WINDOW_LENGTH)
                      ? aosd_pkg::MIN_WINDOW_LENGTH : window_length_reg;
    assign hop      = wlen_eff[aosd_pkg::WLEN_W-1:1];
    assign thr_prod = {12'b0, rms_sq_reg} * {30'b0, wlen_eff};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_mode_reg   <= aosd_pkg::MODE_ENERGY;
            window_length_reg <= aosd_pkg::RST_WINDOW_LENGTH;
            min_gap_reg       <= aosd_pkg::RST_MIN_GAP;
            slice_limit_reg   <= aosd_pkg::RST_SLICE_LIMIT;
            rms_sq_reg        <= aosd_pkg::RST_RMS_SQ;
            energy_thr_reg    <= aosd_pkg::RST_ENERGY_THR;
        end
        else
        begin
            energy_thr_reg <= thr_prod;
            if (cfg_write)
            begin
                unique case (aosd_pkg::cfg_reg_t'(cfg_index))
                    aosd_pkg::CFG_DETECT_MODE:   detect_mode_reg   <= cfg_data[0];
                    aosd_pkg::CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[11:0];
                    aosd_pkg::CFG_RMS_THRESHOLD:
                        rms_sq_reg <= {15'b0, cfg_data[14:0]} * {15'b0, cfg_data[14:0]};
                    aosd_pkg::CFG_MIN_GAP:       min_gap_reg       <= cfg_data;
                    aosd_pkg::CFG_SLICE_LIMIT:   slice_limit_reg   <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mag_reg  <= in_mag;
            sq_reg   <= in_sq;
            neg_reg  <= sample[aosd_pkg::SAMPLE_W-1];
            last_reg <= last_sample;
        end
    end

    // process stage: window tracking, judging and zero crossings
    always_comb
    begin : proc_comb
        logic [aosd_pkg::PHASE_W-1:0] phase;
        logic [NSLOT-1:0]             done;
        aosd_pkg::slot_idx_t          ord [NSLOT];
        logic [aosd_pkg::ENERGY_W+3:0] e4;
        logic [aosd_pkg::ENERGY_W+3:0] p9;

        for (int j = 0; j < NSLOT; j++)
        begin
            energy_next[j]   = energy_reg[j];
            peak_mag_next[j] = peak_mag_reg[j];
            peak_idx_next[j] = peak_idx_reg[j];
            start_next[j]    = start_reg[j];
            count_next[j]    = count_reg[j];
        end
        slot_valid_next  = slot_valid_reg;
        slot_next_next   = slot_next_reg;
        pend_valid_next  = pend_valid_reg;
        pend_energy_next = pend_energy_reg;
        pend_start_next  = pend_start_reg;
        pend_peak_next   = pend_peak_reg;
        prev_energy_next = prev_energy_reg;
        last_slice_next  = last_slice_reg;
        found_next       = found_reg;
        hit_next         = 1'b0;
        pos_next         = '0;
        done             = '0;
        e4               = '0;
        p9               = '0;

        // open a new window on the hop grid
        phase = (hop_phase_reg >= hop) ? '0 : hop_phase_reg;
        if (phase == '0)
        begin
            for (int j = 0; j < NSLOT; j++)
            begin
                if (slot_next_reg == aosd_pkg::slot_idx_t'(j))
                begin
                    energy_next[j]     = '0;
                    peak_mag_next[j]   = '0;
                    peak_idx_next[j]   = sample_index_reg;
                    start_next[j]      = sample_index_reg;
                    count_next[j]      = '0;
                    slot_valid_next[j] = 1'b1;
                end
            end
            slot_next_next = (slot_next_reg == 2'd2) ? 2'd0 : slot_next_reg + 2'd1;
        end
        hop_phase_next = phase + 1'b1;

        // accumulate every open window
        for (int j = 0; j < NSLOT; j++)
        begin
            if (slot_valid_next[j])
            begin
                energy_next[j] = energy_next[j] + {11'b0, sq_reg};
                if (mag_reg > peak_mag_next[j])
                begin
                    peak_mag_next[j] = mag_reg;
                    peak_idx_next[j] = sample_index_reg;
                end
                count_next[j] = count_next[j] + 1'b1;
                done[j]       = (count_next[j] >= wlen_eff);
            end
        end

        // oldest slot first
        ord[0] = slot_next_next;
        ord[1] = (slot_next_next == 2'd2) ? 2'd0 : slot_next_next + 2'd1;
        ord[2] = (slot_next_next == 2'd0) ? 2'd2 : slot_next_next - 2'd1;

        // finished windows judge the pending one, then take its place
        for (int k = 0; k < NSLOT; k++)
        begin
            for (int j = 0; j < NSLOT; j++)
            begin
                if (ord[k] == aosd_pkg::slot_idx_t'(j) && done[j])
                begin
                    if (pend_valid_next)
                    begin
                        e4 = {2'b0, pend_energy_next, 2'b00};
                        p9 = {4'b0, prev_energy_next} + {1'b0, prev_energy_next, 3'b000};
                        if (detect_mode_reg == aosd_pkg::MODE_ENERGY &&
                            rec_ok(found_next, slice_limit_reg) &&
                            pend_energy_next > energy_thr_reg && e4 > p9 &&
                            gap_ok(pend_start_next, last_slice_next, found_next,
                                   min_gap_reg))
                        begin
                            pos_next        = pend_peak_next;
                            last_slice_next = pend_peak_next;
                            found_next      = found_next + 1'b1;
                            hit_next        = 1'b1;
                        end
                        prev_energy_next = pend_energy_next;
                    end
                    pend_valid_next    = 1'b1;
                    pend_energy_next   = energy_next[j];
                    pend_start_next    = start_next[j];
                    pend_peak_next     = peak_idx_next[j];
                    slot_valid_next[j] = 1'b0;
                end
            end
        end

        // zero crossing
        if (sample_index_reg != '0 && neg_reg != prev_neg_reg &&
            detect_mode_reg == aosd_pkg::MODE_ZERO_X &&
            rec_ok(found_next, slice_limit_reg) &&
            gap_ok(sample_index_reg, last_slice_next, found_next, min_gap_reg))
        begin
            pos_next        = sample_index_reg;
            last_slice_next = sample_index_reg;
            found_next      = found_next + 1'b1;
            hit_next        = 1'b1;
        end
        prev_neg_next     = neg_reg;
        sample_index_next = sample_index_reg + 1'b1;

        // slice count reported with this beat, before any end of buffer clear
        count_res_next = found_next;

        // end of buffer returns everything to reset
        if (last_reg)
        begin
            for (int j = 0; j < NSLOT; j++)
            begin
                energy_next[j]   = '0;
                peak_mag_next[j] = '0;
                peak_idx_next[j] = '0;
                start_next[j]    = '0;
                count_next[j]    = '0;
            end
            slot_valid_next   = '0;
            slot_next_next    = '0;
            hop_phase_next    = '0;
            pend_valid_next   = 1'b0;
            pend_energy_next  = '0;
            pend_start_next   = '0;
            pend_peak_next    = '0;
            prev_energy_next  = '0;
            last_slice_next   = '0;
            found_next        = '0;
            prev_neg_next     = 1'b0;
            sample_index_next = '0;
        end
    end

    // buffer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NSLOT; j++)
            begin
                energy_reg[j]   <= '0;
                peak_mag_reg[j] <= '0;
                peak_idx_reg[j] <= '0;
                start_reg[j]    <= '0;
                count_reg[j]    <= '0;
            end
            slot_valid_reg   <= '0;
            slot_next_reg    <= '0;
            hop_phase_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            pend_energy_reg  <= '0;
            pend_start_reg   <= '0;
            pend_peak_reg    <= '0;
            prev_energy_reg  <= '0;
            last_slice_reg   <= '0;
            found_reg        <= '0;
            prev_neg_reg     <= 1'b0;
            sample_index_reg <= '0;
        end
        else if (advance)
        begin
            for (int j = 0; j < NSLOT; j++)
            begin
                energy_reg[j]   <= energy_next[j];
                peak_mag_reg[j] <= peak_mag_next[j];
                peak_idx_reg[j] <= peak_idx_next[j];
                start_reg[j]    <= start_next[j];
                count_reg[j]    <= count_next[j];
            end
            slot_valid_reg   <= slot_valid_next;
            slot_next_reg    <= slot_next_next;
            hop_phase_reg    <= hop_phase_next;
            pend_valid_reg   <= pend_valid_next;
            pend_energy_reg  <= pend_energy_next;
            pend_start_reg   <= pend_start_next;
            pend_peak_reg    <= pend_peak_next;
            prev_energy_reg  <= prev_energy_next;
            last_slice_reg   <= last_slice_next;
            found_reg        <= found_next;
            prev_neg_reg     <= prev_neg_next;
            sample_index_reg <= sample_index_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= hit_next || last_reg;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slice_valid_reg    <= hit_next;
            slice_position_reg <= pos_next;
            slice_count_reg    <= count_res_next;
            end_of_buffer_reg  <= last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign slice_valid    = slice_valid_reg;
    assign slice_position = slice_position_reg;
    assign slice_count    = slice_count_reg;
    assign end_of_buffer  = end_of_buffer_reg;

    // checks
    `AOSD_ASSERT_IMPL(a_slice_has_count, out_valid_reg && slice_valid_reg,
        slice_count_reg != '0, "slice beat reports a zero slice count")
    `AOSD_ASSERT_IMPL(a_empty_is_eob, out_valid_reg && !slice_valid_reg,
        end_of_buffer_reg, "result beat without slice or end of buffer")
    `AOSD_ASSERT_NEXT(a_eob_clears, advance && last_reg,
        sample_index_reg == '0 && found_reg == '0 && !pend_valid_reg,
        "buffer state not cleared after last sample")

endmodule
`default_nettype wire
